// ===== rtl/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared beat types, round constants and mixing functions of the hash engine.
// ----------------------------------------------------------------------------
package sha256_pkg;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        message_end;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  digest_index;
      logic        digest_last;
   } rsp_type;

   typedef logic [31:0] hash_array_type [8];

   typedef struct packed {
      logic        shift;
      logic        expand;
      logic [31:0] word;
   } sched_ctl_type;

   typedef struct packed {
      logic load;
      logic step;
      logic fold;
      logic restart;
   } round_ctl_type;

   localparam logic [31:0] PAD_WORD = 32'h8000_0000;

   localparam hash_array_type INIT_HASH = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   // Keep the leading bytes of a short final word and place the pad byte
   // right after them.
   function automatic logic [31:0] pack_last(input logic [31:0] w, input logic [1:0] n);
      logic [31:0] r;
      unique case (n)
         2'd0: r = PAD_WORD;
         2'd1: r = {w[31:24], 8'h80, 16'h0000};
         2'd2: r = {w[31:16], 8'h80, 8'h00};
         2'd3: r = {w[31:8], 8'h80};
         default: r = PAD_WORD;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/sha256_hash_engine.sv =====
// ----------------------------------------------------------------------------
// sha256_hash_engine
// SHA-256 engine: packs message words into blocks, pads and emits the digest.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one big-endian message word per beat with its count
//   of valid leading bytes and an end-of-message flag. The count matters only
//   on the final beat; other beats always count as four bytes.
//   rsp channel returns the eight digest words, index 0 first, with
//   digest_last on index 7, after the final request beat.
// Flow:
//   A non-final word is taken while idle; the sixteenth word of a block starts
//   64 rounds on the one shared round unit plus a chain fold, and no request
//   is taken until they are done. Padding writes one word per cycle and may
//   need a second compression. The first digest word is registered in the
//   output phase that follows the chain fold after the last round.
// Reset:
//   Synchronous reset loads the initial hash values and clears the byte
//   count and block fill. After the digest the engine starts a new message.
// Stalls:
//   The result register holds a digest word until taken; the engine waits
//   in its output phase while rsp_ready is low and takes no request beat.
// ----------------------------------------------------------------------------
module sha256_hash_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sha256_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sha256_pkg::rsp_type rsp_data
);
   import sha256_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PAD   = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_FOLD  = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   localparam logic [1:0] TAIL_IDLE = 2'd0;
   localparam logic [1:0] TAIL_PAD  = 2'd1;
   localparam logic [1:0] TAIL_OUT  = 2'd2;

   logic [2:0]     state_ff, state_in;
   logic [1:0]     tail_ff, tail_in;
   logic [3:0]     word_cnt_ff, word_cnt_in;
   logic [63:0]    len_ff, len_in;
   logic           pad80_ff, pad80_in;
   logic           len_phase_ff, len_phase_in;
   logic [5:0]     round_ff, round_in;
   logic [2:0]     idx_ff, idx_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff;

   logic           req_fire;
   logic           out_load;
   logic [2:0]     eff_cnt;
   logic [63:0]    len_bits;
   logic [31:0]    w_now;
   hash_array_type chain_value;
   sched_ctl_type  sched_ctl;
   round_ctl_type  round_ctl;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign eff_cnt   = (!req_data.message_end || req_data.byte_count > 3'd4) ? 3'd4
                                                                          : req_data.byte_count;
   assign len_bits  = {len_ff[60:0], 3'b000};

   always_comb begin
      state_in     = state_ff;
      tail_in      = tail_ff;
      word_cnt_in  = word_cnt_ff;
      len_in       = len_ff;
      pad80_in     = pad80_ff;
      len_phase_in = len_phase_ff;
      round_in     = round_ff;
      idx_in       = idx_ff;
      out_load     = 1'b0;
      sched_ctl    = '0;
      round_ctl    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               sched_ctl.shift = 1'b1;
               len_in          = len_ff + 64'(eff_cnt);
               word_cnt_in     = word_cnt_ff + 4'd1;
               tail_in         = req_data.message_end ? TAIL_PAD : TAIL_IDLE;
               if (!req_data.message_end || eff_cnt == 3'd4) begin
                  sched_ctl.word = req_data.data_word;
                  pad80_in       = req_data.message_end;
               end else begin
                  sched_ctl.word = pack_last(req_data.data_word, eff_cnt[1:0]);
               end
               if (word_cnt_ff == 4'd15) begin
                  round_ctl.load = 1'b1;
                  round_in       = '0;
                  state_in       = ST_ROUND;
               end else if (req_data.message_end) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            sched_ctl.shift = 1'b1;
            word_cnt_in     = word_cnt_ff + 4'd1;
            priority if (pad80_ff) begin
               sched_ctl.word = PAD_WORD;
               pad80_in       = 1'b0;
            end else if (word_cnt_ff == 4'd14) begin
               sched_ctl.word = len_bits[63:32];
               len_phase_in   = 1'b1;
            end else if (len_phase_ff && word_cnt_ff == 4'd15) begin
               sched_ctl.word = len_bits[31:0];
            end else begin
               sched_ctl.word = '0;
            end
            if (word_cnt_ff == 4'd15) begin
               round_ctl.load = 1'b1;
               round_in       = '0;
               state_in       = ST_ROUND;
               tail_in        = (len_phase_ff && !pad80_ff) ? TAIL_OUT : TAIL_PAD;
            end
         end
         ST_ROUND: begin
            sched_ctl.expand = 1'b1;
            round_ctl.step   = 1'b1;
            round_in         = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            round_ctl.fold = 1'b1;
            unique case (tail_ff)
               TAIL_PAD: state_in = ST_PAD;
               TAIL_OUT: begin
                  state_in     = ST_OUT;
                  idx_in       = '0;
                  len_phase_in = 1'b0;
               end
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               idx_in   = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  round_ctl.restart = 1'b1;
                  len_in            = '0;
                  state_in          = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tail_ff      <= TAIL_IDLE;
         word_cnt_ff  <= '0;
         len_ff       <= '0;
         pad80_ff     <= 1'b0;
         len_phase_ff <= 1'b0;
         round_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tail_ff      <= tail_in;
         word_cnt_ff  <= word_cnt_in;
         len_ff       <= len_in;
         pad80_ff     <= pad80_in;
         len_phase_ff <= len_phase_in;
         round_ff     <= round_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the digest beat until the receiver takes it.
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff.digest_word  <= chain_value[idx_ff];
         rsp_data_ff.digest_index <= idx_ff;
         rsp_data_ff.digest_last  <= (idx_ff == 3'd7);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   sha256_sched u_sched (
      .clock (clock),
      .ctl   (sched_ctl),
      .w_now (w_now)
   );

   sha256_round u_round (
      .clock       (clock),
      .reset       (reset),
      .ctl         (round_ctl),
      .round_idx   (round_ff),
      .w_now       (w_now),
      .chain_value (chain_value)
   );

   a_round_to_fold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND && round_ff == 6'd63 |=> state_ff == ST_FOLD)
      else $error("round counter did not hand over to fold");

   a_block_starts_rounds: assert property (@(posedge clock) disable iff (reset)
      req_fire && word_cnt_ff == 4'd15 |=> state_ff == ST_ROUND && round_ff == 6'd0)
      else $error("full block did not start compression");

   a_restart_after_digest: assert property (@(posedge clock) disable iff (reset)
      out_load && idx_ff == 3'd7 |=> state_ff == ST_IDLE && len_ff == 64'd0
                                     && word_cnt_ff == 4'd0)
      else $error("engine did not restart after the digest");

   a_length_tail_aligned: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAD && len_phase_ff |-> word_cnt_ff == 4'd15 && !pad80_ff)
      else $error("length words out of place in the final block");

endmodule

// ===== rtl/sha256_sched.sv =====
// ----------------------------------------------------------------------------
// sha256_sched
// Sixteen-word message schedule window: loads block words, then expands.
// ----------------------------------------------------------------------------
module sha256_sched (
   input  logic                      clock,
   input  sha256_pkg::sched_ctl_type ctl,
   output logic [31:0]               w_now
);
   import sha256_pkg::*;

   logic [31:0] w_ff [16];
   logic [31:0] w_next;

   always_comb begin
      w_next = ctl.shift ? ctl.word
                         : small_sigma1(w_ff[14]) + w_ff[9] + small_sigma0(w_ff[1]) + w_ff[0];
   end

   // Slide the window one word; the newest word enters at the top.
   always_ff @(posedge clock) begin
      if (ctl.shift || ctl.expand) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[15] <= w_next;
      end
   end

   assign w_now = w_ff[0];

endmodule

// ===== rtl/sha256_round.sv =====
// ----------------------------------------------------------------------------
// sha256_round
// Compression round unit with working variables and the chained hash value.
// ----------------------------------------------------------------------------
module sha256_round (
   input  logic                       clock,
   input  logic                       reset,
   input  sha256_pkg::round_ctl_type  ctl,
   input  logic [5:0]                 round_idx,
   input  logic [31:0]                w_now,
   output sha256_pkg::hash_array_type chain_value
);
   import sha256_pkg::*;

   hash_array_type chain_ff;
   hash_array_type v_ff;
   logic [31:0]    t1;
   logic [31:0]    t2;
   logic [31:0]    ch;
   logic [31:0]    maj;

   always_comb begin
      ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1  = v_ff[7] + big_sigma1(v_ff[4]) + ch + ROUND_K[round_idx] + w_now;
      t2  = big_sigma0(v_ff[0]) + maj;
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         v_ff <= chain_ff;
      end else if (ctl.step) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.restart) begin
         chain_ff <= INIT_HASH;
      end else if (ctl.fold) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= chain_ff[i] + v_ff[i];
         end
      end
   end

   assign chain_value = chain_ff;

endmodule

// ===== sim/tb_sha256_hash_engine.sv =====
// ----------------------------------------------------------------------------
// tb_sha256_hash_engine
// Streams messages into the hash engine and checks every digest word against
// a behavioral SHA-256 model kept in the bench. A short directed set covers
// empty, short and padded-over messages and odd byte counts. Random messages
// follow, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_sha256_hash_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import sha256_pkg::*;

   localparam int unsigned IDLE_LIMIT     = 5000;
   localparam int unsigned RANDOM_ITEMS   = 385;
   localparam int unsigned LONG_HOLD      = 400;
   localparam int unsigned HOLD_AT_WORD   = 57;
   localparam int unsigned DRAIN_CYCLES   = 200;

   localparam logic [31:0] H0 [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   localparam logic [31:0] K_TABLE [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct {
      req_type     beat;
      int unsigned gap;
      bit          drain;
   } word_slot_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // model state
   logic [31:0] chain_h [8];
   logic [31:0] block_w [16];
   int unsigned block_fill;
   logic [63:0] msg_bytes;

   word_slot_type msg_word_q [$];
   rsp_type       pending_digest_q [$];
   word_slot_type next_slot;

   logic        req_took = 1'b0;
   int unsigned req_gap_left = 0;
   int unsigned rsp_hold_left = 0;
   int unsigned rsp_calm_left = 0;
   int unsigned rsp_roll;
   bit          long_hold_done = 1'b0;
   int unsigned rsp_words_seen = 0;
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles = 0;

   sha256_hash_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void sha_restart();
      int i;
      for (i = 0; i < 8; i++) chain_h[i] = H0[i];
      block_fill = 0;
      msg_bytes  = '0;
   endfunction

   function automatic void sha_compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      int t;
      for (t = 0; t < 16; t++) w[t] = block_w[t];
      for (t = 16; t < 64; t++) begin
         w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
              + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
      end
      for (t = 0; t < 8; t++) v[t] = chain_h[t];
      for (t = 0; t < 64; t++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[t] + w[t];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (t = 0; t < 8; t++) chain_h[t] = chain_h[t] + v[t];
   endfunction

   function automatic void sha_put_byte(input logic [7:0] b);
      int unsigned slot, shift;
      slot  = (block_fill >> 2) & 15;
      shift = (3 - (block_fill & 3)) * 8;
      if ((block_fill & 3) == 0) begin
         block_w[slot] = {b, 24'h0};
      end else begin
         block_w[slot] = block_w[slot] | (32'(b) << shift);
      end
      block_fill = (block_fill + 1) & 63;
      if (block_fill == 0) sha_compress();
   endfunction

   // Absorb one accepted beat; on the final beat pad and queue the digest.
   function automatic void sha_absorb_beat(input req_type beat);
      int unsigned n;
      int i;
      logic [63:0] bits;
      rsp_type d;
      n = beat.byte_count;
      if (!beat.message_end || n > 4) n = 4;
      for (i = 0; i < n; i++) sha_put_byte(beat.data_word[31 - 8*i -: 8]);
      msg_bytes = msg_bytes + 64'(n);
      if (!beat.message_end) return;
      sha_put_byte(8'h80);
      while (block_fill != 56) sha_put_byte(8'h00);
      bits = msg_bytes << 3;
      for (i = 0; i < 8; i++) sha_put_byte(bits[63 - 8*i -: 8]);
      for (i = 0; i < 8; i++) begin
         d.digest_word  = chain_h[i];
         d.digest_index = 3'(i);
         d.digest_last  = (i == 7);
         pending_digest_q.push_back(d);
      end
      sha_restart();
   endfunction

   function automatic int unsigned pick_gap(input bit busy);
      int unsigned r;
      if (busy) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 50);
   endfunction

   task automatic push_word(input logic [31:0] data, input logic [2:0] cnt, input logic last,
                            input int unsigned gap, input bit drain);
      word_slot_type s;
      s.beat.data_word   = data;
      s.beat.byte_count  = cnt;
      s.beat.message_end = last;
      s.gap   = gap;
      s.drain = drain;
      msg_word_q.push_back(s);
   endtask

   // Sender: accept at the rising edge, update the model there.
   always @(posedge clock) begin
      req_took <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) sha_absorb_beat(req_data);
   end

   // Sender: drive at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_took) begin
         // hold the beat until taken
      end else if (req_gap_left > 0) begin
         req_valid    <= 1'b0;
         req_gap_left <= req_gap_left - 1;
      end else if (msg_word_q.size() != 0 &&
                   !(msg_word_q[0].drain && pending_digest_q.size() != 0)) begin
         next_slot = msg_word_q.pop_front();
         req_data     <= next_slot.beat;
         req_valid    <= 1'b1;
         req_gap_left <= next_slot.gap;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: check each digest beat against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_words_seen++;
         if (pending_digest_q.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected beat: expected none, actual %h idx %0d last %0b",
                     $realtime, rsp_data.digest_word, rsp_data.digest_index,
                     rsp_data.digest_last);
         end else begin
            if (rsp_data.digest_word !== pending_digest_q[0].digest_word ||
                rsp_data.digest_index !== pending_digest_q[0].digest_index ||
                rsp_data.digest_last !== pending_digest_q[0].digest_last) begin
               mismatch_count++;
               $display("%0t: mismatch: expected %h/%0d/%0b, actual %h/%0d/%0b",
                        $realtime, pending_digest_q[0].digest_word,
                        pending_digest_q[0].digest_index, pending_digest_q[0].digest_last,
                        rsp_data.digest_word, rsp_data.digest_index, rsp_data.digest_last);
            end
            void'(pending_digest_q.pop_front());
         end
      end
   end

   // Receiver: ready pattern, with one long hold while the sender keeps offering.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_ready     <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else if (!long_hold_done && rsp_words_seen >= HOLD_AT_WORD) begin
         long_hold_done = 1'b1;
         rsp_ready     <= 1'b0;
         rsp_hold_left <= LONG_HOLD;
      end else if (rsp_calm_left > 0) begin
         rsp_ready     <= 1'b1;
         rsp_calm_left <= rsp_calm_left - 1;
      end else begin
         rsp_roll = $urandom_range(0, 99);
         if (rsp_roll < 60) begin
            rsp_ready <= 1'b1;
         end else if (rsp_roll < 68) begin
            rsp_ready     <= 1'b1;
            rsp_calm_left <= $urandom_range(20, 80);
         end else if (rsp_roll < 95) begin
            rsp_ready     <= 1'b0;
            rsp_hold_left <= $urandom_range(0, 2);
         end else begin
            rsp_ready     <= 1'b0;
            rsp_hold_left <= $urandom_range(10, 60);
         end
      end
   end

   // Watchdog: count cycles with no beat on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $realtime, idle_cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int i, m, n;
      int unsigned total, r;
      bit busy;
      logic [2:0] cnt;
      sha_restart();

      // empty message; the ignored bytes are all ones
      push_word(32'hFFFF_FFFF, 3'd0, 1'b1, 0, 1'b0);
      // count above four on the final beat
      push_word(32'h0000_0000, 3'd7, 1'b1, 1, 1'b0);
      // "abc" with junk in the byte past the count
      push_word(32'h6162_63FF, 3'd3, 1'b1, 0, 1'b0);
      push_word(32'hFFFF_FFFF, 3'd4, 1'b0, 0, 1'b0);
      push_word(32'h8000_0000, 3'd4, 1'b1, 2, 1'b0);
      // short and oversized counts on non-final beats, 59 bytes so padding spills a block
      push_word(32'h0000_0000, 3'd0, 1'b0, 0, 1'b0);
      push_word(32'hFFFF_FFFF, 3'd1, 1'b0, 0, 1'b0);
      push_word($urandom, 3'd2, 1'b0, 1, 1'b0);
      push_word($urandom, 3'd3, 1'b0, 0, 1'b0);
      push_word($urandom, 3'd5, 1'b0, 0, 1'b0);
      push_word($urandom, 3'd6, 1'b0, 0, 1'b0);
      push_word($urandom, 3'd7, 1'b0, 0, 1'b0);
      for (i = 0; i < 7; i++) push_word($urandom, 3'd4, 1'b0, 0, 1'b0);
      push_word($urandom, 3'd3, 1'b1, 0, 1'b0);

      total = 0;
      m = 0;
      while (total < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 70) n = $urandom_range(1, 16);
         else if (r < 95) n = $urandom_range(17, 32);
         else n = $urandom_range(33, 48);
         busy = ($urandom_range(0, 3) == 0);
         for (i = 0; i < n; i++) begin
            if (i == n - 1) cnt = 3'($urandom_range(0, 7));
            else if ($urandom_range(0, 3) != 0) cnt = 3'd4;
            else cnt = 3'($urandom_range(0, 7));
            // pause until all digests are back at the start of random messages 0 and 12
            push_word($urandom, cnt, i == n - 1, pick_gap(busy),
                      i == 0 && (m == 0 || m == 12));
         end
         total += n;
         m++;
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (msg_word_q.size() != 0 || req_valid || pending_digest_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && pending_digest_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
